/* rtl/core/ilf_pkg.sv */
// ----------------------------------------------------------------------------
// ilf_pkg
// Shared constants, request types and helpers for the incremental line fit.
// ----------------------------------------------------------------------------
package ilf_pkg;

  localparam int MAX_POINTS = 4096;
  localparam int COORD_BITS = 20;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int OP_W       = 64;
  localparam int PROD_W     = 2 * OP_W;
  localparam int NB_W       = $clog2(OP_W + 1);
  localparam int DIV_W      = 88;
  localparam int DCNT_W     = $clog2(DIV_W + 1);

  typedef struct packed {
    logic            start;
    logic [OP_W-1:0] a;
    logic [OP_W-1:0] b;
    logic [NB_W-1:0] nbits;
  } mul_req_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [OP_W-1:0]  den;
  } div_req_t;

  function automatic logic [OP_W-1:0] mag64(input logic signed [OP_W-1:0] v);
    mag64 = v[OP_W-1] ? OP_W'(-v) : OP_W'(v);
  endfunction

  // Apply sign to a rounded quotient and saturate to a signed field of bits.
  function automatic logic signed [47:0] sat_quot(input logic [DIV_W-1:0] q,
                                                  input logic neg, input int bits);
    logic [DIV_W-1:0] lim;
    lim = (DIV_W'(1) << (bits - 1)) - DIV_W'(1);
    if (neg) begin
      if (q > lim + DIV_W'(1)) sat_quot = -$signed({1'b0, 47'(lim)}) - 48'sd1;
      else sat_quot = -$signed(48'(q));
    end else begin
      if (q > lim) sat_quot = $signed(48'(lim));
      else sat_quot = $signed(48'(q));
    end
  endfunction

endpackage

/* rtl/core/ilf_mul.sv */
// ----------------------------------------------------------------------------
// ilf_mul
// Bit-serial unsigned multiplier: one multiplier bit per cycle, LSB first.
// ----------------------------------------------------------------------------
module ilf_mul (
  input  logic                     clk,
  input  logic                     rst,
  input  ilf_pkg::mul_req_t        req,
  output logic                     done,
  output logic [ilf_pkg::PROD_W-1:0] prod
);
  import ilf_pkg::*;

  logic [PROD_W-1:0] acc;
  logic [PROD_W-1:0] areg;
  logic [OP_W-1:0]   breg;
  logic [NB_W-1:0]   cnt;
  logic              run;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run <= 1'b1;
        cnt <= req.nbits;
        acc <= '0;
        areg <= PROD_W'(req.a);
        breg <= req.b;
      end else if (run) begin
        if (breg[0]) acc <= acc + areg;
        areg <= areg << 1;
        breg <= breg >> 1;
        cnt  <= cnt - NB_W'(1);
        if (cnt == NB_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign prod = acc;

endmodule

/* rtl/core/ilf_div.sv */
// ----------------------------------------------------------------------------
// ilf_div
// Restoring unsigned divider: one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module ilf_div (
  input  logic                      clk,
  input  logic                      rst,
  input  ilf_pkg::div_req_t         req,
  output logic                      done,
  output logic [ilf_pkg::DIV_W-1:0] quot
);
  import ilf_pkg::*;

  logic [DIV_W-1:0]  nreg;
  logic [OP_W-1:0]   den;
  logic [OP_W-1:0]   rem;
  logic [DIV_W-1:0]  q;
  logic [DCNT_W-1:0] cnt;
  logic              run;
  logic [OP_W:0]     trial;
  logic              take;

  assign trial = {rem, nreg[DIV_W-1]};
  assign take  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run  <= 1'b1;
        cnt  <= DCNT_W'(DIV_W);
        nreg <= req.num;
        den  <= req.den;
        rem  <= '0;
        q    <= '0;
      end else if (run) begin
        rem  <= take ? OP_W'(trial - {1'b0, den}) : OP_W'(trial);
        q    <= {q[DIV_W-2:0], take};
        nreg <= nreg << 1;
        cnt  <= cnt - DCNT_W'(1);
        if (cnt == DCNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = q;

endmodule

/* rtl/core/incremental_line_fit_collinearity_core.sv */
// ----------------------------------------------------------------------------
// incremental_line_fit_collinearity_core
// Running least-squares line fit over a point stream with a distance test.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid/in_stall    new_set, x_coord, y_coord
//   out      source     out_valid/out_stall  aligned, point_count, line_valid,
//                                            slope, intercept
//   cfg      sink       cfg_valid/cfg_ready  cfg_data (max_distance)
//
// One item at a time. All products run through one bit-serial multiplier
// (one bit per cycle) and the two quotients through a bit-serial divider;
// an item runs the distance test, the sum update and a refit, each as needed.
// Synchronous reset clears the set and loads max_distance with 16.
// A stalled result is held in the output register; the next item is taken
// meanwhile and waits at the end of its work for the register to free up.
// ----------------------------------------------------------------------------
module incremental_line_fit_collinearity_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               new_set,
  input  logic signed [ilf_pkg::COORD_BITS-1:0] x_coord,
  input  logic signed [ilf_pkg::COORD_BITS-1:0] y_coord,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               aligned,
  output logic [12:0]                        point_count,
  output logic                               line_valid,
  output logic signed [31:0]                 slope,
  output logic signed [23:0]                 intercept,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [15:0]                        cfg_data
);
  import ilf_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0,  S_T1  = 5'd1,  S_T2  = 5'd2,  S_T3  = 5'd3,
                         S_T4   = 5'd4,  S_T5  = 5'd5,  S_SXX = 5'd6,  S_SXY = 5'd7,
                         S_R1   = 5'd8,  S_R2  = 5'd9,  S_R3  = 5'd10, S_R4  = 5'd11,
                         S_RD1  = 5'd12, S_R6  = 5'd13, S_R7  = 5'd14, S_RD2 = 5'd15,
                         S_DONE = 5'd16;

  logic [4:0]  state;
  logic        wait_q;
  logic [15:0] max_distance;

  logic [CNT_W-1:0]         count;
  logic                     still_aligned;
  logic                     room;
  logic signed [39:0]       sum_x, sum_y;
  logic signed [63:0]       sum_xx, sum_xy;
  logic signed [31:0]       line_slope;
  logic signed [47:0]       line_icpt;
  logic                     have_line;
  logic signed [COORD_BITS-1:0] xin, yin;

  logic [47:0]              mres;
  logic [95:0]              m2;
  logic [63:0]              s2;
  logic [31:0]              d2;
  logic signed [PROD_W-1:0] t1;
  logic [63:0]              dreg;
  logic                     div_neg;
  logic [DIV_W-1:0]         div_num;
  logic                     mul_neg, mul_neg_next;

  mul_req_t          mreq;
  div_req_t          dreq;
  logic              mul_done, div_done;
  logic [PROD_W-1:0] prod;
  logic [DIV_W-1:0]  quot;

  ilf_mul u_mul (.clk(clk), .rst(rst), .req(mreq), .done(mul_done), .prod(prod));
  ilf_div u_div (.clk(clk), .rst(rst), .req(dreq), .done(div_done), .quot(quot));

  // Sign-extended operands
  logic signed [OP_W-1:0] x64, y64, sl64, sx64, sy64;
  assign x64  = OP_W'(xin);
  assign y64  = OP_W'(yin);
  assign sl64 = OP_W'(line_slope);
  assign sx64 = OP_W'(sum_x);
  assign sy64 = OP_W'(sum_y);

  logic is_mul, is_div;
  always_comb begin
    mreq.a = '0;
    mreq.b = '0;
    mreq.nbits = NB_W'(1);
    mul_neg_next = 1'b0;
    is_mul = 1'b1;
    is_div = 1'b0;
    case (state)
      S_T1: begin
        mreq.a = mag64(sl64); mreq.b = mag64(x64); mreq.nbits = NB_W'(COORD_BITS);
        mul_neg_next = line_slope[31] ^ xin[COORD_BITS-1];
      end
      S_T2: begin
        mreq.a = OP_W'(mres); mreq.b = OP_W'(mres); mreq.nbits = NB_W'(48);
      end
      S_T3: begin
        mreq.a = mag64(sl64); mreq.b = mag64(sl64); mreq.nbits = NB_W'(32);
      end
      S_T4: begin
        mreq.a = OP_W'(max_distance); mreq.b = OP_W'(max_distance); mreq.nbits = NB_W'(16);
      end
      S_T5: begin
        mreq.a = s2; mreq.b = OP_W'(d2); mreq.nbits = NB_W'(32);
      end
      S_SXX: begin
        mreq.a = mag64(x64); mreq.b = mag64(x64); mreq.nbits = NB_W'(COORD_BITS);
      end
      S_SXY: begin
        mreq.a = mag64(x64); mreq.b = mag64(y64); mreq.nbits = NB_W'(COORD_BITS);
        mul_neg_next = xin[COORD_BITS-1] ^ yin[COORD_BITS-1];
      end
      S_R1: begin
        mreq.a = mag64(sum_xx); mreq.b = OP_W'(count); mreq.nbits = NB_W'(CNT_W);
        mul_neg_next = sum_xx[63];
      end
      S_R2: begin
        mreq.a = mag64(sx64); mreq.b = mag64(sx64); mreq.nbits = NB_W'(40);
      end
      S_R3: begin
        mreq.a = mag64(sum_xy); mreq.b = OP_W'(count); mreq.nbits = NB_W'(CNT_W);
        mul_neg_next = sum_xy[63];
      end
      S_R4: begin
        mreq.a = mag64(sx64); mreq.b = mag64(sy64); mreq.nbits = NB_W'(40);
        mul_neg_next = sum_x[39] ^ sum_y[39];
      end
      S_R6: begin
        mreq.a = mag64(sum_xx); mreq.b = mag64(sy64); mreq.nbits = NB_W'(40);
        mul_neg_next = sum_xx[63] ^ sum_y[39];
      end
      S_R7: begin
        mreq.a = mag64(sum_xy); mreq.b = mag64(sx64); mreq.nbits = NB_W'(40);
        mul_neg_next = sum_xy[63] ^ sum_x[39];
      end
      S_RD1, S_RD2: begin
        is_mul = 1'b0;
        is_div = 1'b1;
      end
      default: is_mul = 1'b0;
    endcase
    mreq.start = is_mul && !wait_q;
    dreq.start = is_div && !wait_q;
    dreq.num   = div_num;
    dreq.den   = {dreg[62:0], 1'b0};
  end

  logic op_done;
  assign op_done = wait_q && ((is_mul && mul_done) || (is_div && div_done));

  // Signed product and the arithmetic that consumes it
  logic signed [PROD_W-1:0] prod_s, resid, diff, num_s;
  logic [PROD_W-1:0]        rmag, nmag;
  assign prod_s = mul_neg ? -$signed(prod) : $signed(prod);
  assign resid  = (PROD_W'(yin) <<< 16) - prod_s - (PROD_W'(line_icpt) <<< 16);
  assign rmag   = resid[PROD_W-1] ? PROD_W'(-resid) : PROD_W'(resid);
  assign diff   = t1 - prod_s;
  assign num_s  = (state == S_R4) ? (diff <<< 16) : diff;
  assign nmag   = num_s[PROD_W-1] ? PROD_W'(-num_s) : PROD_W'(num_s);

  logic signed [47:0] qsat32, qsat48;
  assign qsat32 = sat_quot(quot, div_neg, 32);
  assign qsat48 = sat_quot(quot, div_neg, 48);

  // Accept-time bookkeeping
  logic [CNT_W-1:0] base_cnt, cnt_next;
  logic             base_al, room_next;
  assign base_cnt  = new_set ? '0 : count;
  assign base_al   = new_set ? 1'b1 : still_aligned;
  assign room_next = base_cnt < CNT_W'(MAX_POINTS);
  assign cnt_next  = room_next ? base_cnt + CNT_W'(1) : base_cnt;

  logic out_free;
  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      wait_q        <= 1'b0;
      out_valid     <= 1'b0;
      max_distance  <= 16'd16;
      count         <= '0;
      still_aligned <= 1'b1;
      sum_x         <= '0;
      sum_y         <= '0;
      sum_xx        <= '0;
      sum_xy        <= '0;
      line_slope    <= '0;
      line_icpt     <= '0;
      have_line     <= 1'b0;
    end else begin
      if (cfg_valid) max_distance <= cfg_data;
      if (out_valid && !out_stall && state != S_DONE) out_valid <= 1'b0;
      if (mreq.start || dreq.start) begin
        wait_q  <= 1'b1;
        mul_neg <= mul_neg_next;
      end
      if (op_done) wait_q <= 1'b0;

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            xin           <= x_coord;
            yin           <= y_coord;
            count         <= cnt_next;
            room          <= room_next;
            still_aligned <= base_al;
            if (new_set) begin
              sum_x      <= '0;
              sum_y      <= '0;
              sum_xx     <= '0;
              sum_xy     <= '0;
              line_slope <= '0;
              line_icpt  <= '0;
              have_line  <= 1'b0;
            end
            if (cnt_next > CNT_W'(2) && base_al) state <= S_T1;
            else if (base_al && room_next) state <= S_SXX;
            else state <= S_DONE;
          end
        end
        S_T1: if (op_done) begin
          mres <= rmag[47:0];
          // residual of 2^48 or more can never pass
          if (|rmag[PROD_W-1:48]) begin
            still_aligned <= 1'b0;
            state <= S_DONE;
          end else state <= S_T2;
        end
        S_T2: if (op_done) begin
          m2 <= prod[95:0];
          state <= S_T3;
        end
        S_T3: if (op_done) begin
          s2 <= (64'd1 << 32) + prod[63:0];
          state <= S_T4;
        end
        S_T4: if (op_done) begin
          d2 <= prod[31:0];
          state <= S_T5;
        end
        S_T5: if (op_done) begin
          still_aligned <= m2 < prod[95:0];
          state <= (m2 < prod[95:0] && room) ? S_SXX : S_DONE;
        end
        S_SXX: if (op_done) begin
          sum_x  <= sum_x + 40'(xin);
          sum_y  <= sum_y + 40'(yin);
          sum_xx <= sum_xx + $signed(prod[63:0]);
          state  <= S_SXY;
        end
        S_SXY: if (op_done) begin
          sum_xy <= sum_xy + prod_s[63:0];
          state  <= (count > CNT_W'(1)) ? S_R1 : S_DONE;
        end
        S_R1: if (op_done) begin
          t1 <= prod_s;
          state <= S_R2;
        end
        S_R2: if (op_done) begin
          // zero or negative x variance: mark the line invalid
          if (diff[PROD_W-1] || diff == '0) begin
            have_line <= 1'b0;
            state <= S_DONE;
          end else begin
            dreg  <= diff[63:0];
            state <= S_R3;
          end
        end
        S_R3: if (op_done) begin
          t1 <= prod_s;
          state <= S_R4;
        end
        S_R4, S_R7: if (op_done) begin
          div_neg <= num_s[PROD_W-1];
          div_num <= (DIV_W'(nmag) << 1) + DIV_W'(dreg);
          state   <= (state == S_R4) ? S_RD1 : S_RD2;
        end
        S_RD1: if (op_done) begin
          line_slope <= qsat32[31:0];
          state <= S_R6;
        end
        S_R6: if (op_done) begin
          t1 <= prod_s;
          state <= S_R7;
        end
        S_RD2: if (op_done) begin
          line_icpt <= qsat48;
          have_line <= 1'b1;
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            aligned     <= still_aligned;
            point_count <= 13'(count);
            line_valid  <= have_line;
            slope       <= line_slope;
            if (line_icpt > 48'sd8388607) intercept <= 24'sh7FFFFF;
            else if (line_icpt < -48'sd8388608) intercept <= 24'sh800000;
            else intercept <= line_icpt[23:0];
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
